### sv/rpfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfc_pkg
// Shared types, register codes and divide helpers of the RGB565 converter.
// ----------------------------------------------------------------------------
package rpfc_pkg;

    localparam int PIX_W     = 16;  // RGB565 input pixel
    localparam int MAX_W     = 16;  // client component maximum
    localparam int POS_W     = 5;   // component position
    localparam int XW        = 22;  // c * max + half, c <= 63
    localparam int QW        = 16;  // scaled component, never above max
    localparam int RW        = 9;   // remainder left after the estimate
    localparam int WORD_W    = 32;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int NLANE     = 3;   // red, green, blue

    typedef logic [XW-1:0] t_x;
    typedef logic [QW-1:0] t_q;
    typedef logic [RW-1:0] t_rem;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SIZE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_BYTES      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_MAX         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MAX       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MAX        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_POS         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_POS       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_POS        = 3'd7;

    // pixel size modes
    localparam logic [1:0] SIZE_ONE  = 2'd0;
    localparam logic [1:0] SIZE_TWO  = 2'd1;
    localparam logic [1:0] SIZE_FOUR = 2'd2;

    localparam logic [CNT_W-1:0] CNT_ONE  = 3'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 3'd2;
    localparam logic [CNT_W-1:0] CNT_FOUR = 3'd4;

    // Lower bound on x/31 (six == 0) or x/63 (six == 1) from the series
    // 1/(2^k - 1) = sum 2^-kn. Never above the true quotient, short by < 5.
    function automatic t_q est_quot(input t_x x, input logic six);
        t_x s;
        if (six) begin
            s = (x >> 6) + (x >> 12) + (x >> 18);
        end else begin
            s = (x >> 5) + (x >> 10) + (x >> 15) + (x >> 20);
        end
        return s[QW-1:0];
    endfunction

    // x - 31*q or x - 63*q, known to be small and non-negative
    function automatic t_rem remainder(input t_x x, input t_q q, input logic six);
        t_x qx;
        t_x d;
        qx = {{(XW-QW){1'b0}}, q};
        if (six) begin
            d = x - ((qx << 6) - qx);
        end else begin
            d = x - ((qx << 5) - qx);
        end
        return d[RW-1:0];
    endfunction

    // quotient of the leftover remainder: count of multiples reached
    function automatic logic [2:0] rem_quot(input t_rem r, input logic six);
        logic [2:0] c;
        if (six) begin
            c = 3'(r >= 9'd63) + 3'(r >= 9'd126) + 3'(r >= 9'd189)
              + 3'(r >= 9'd252);
        end else begin
            c = 3'(r >= 9'd31) + 3'(r >= 9'd62) + 3'(r >= 9'd93)
              + 3'(r >= 9'd124) + 3'(r >= 9'd155);
        end
        return c;
    endfunction

endpackage

### sv/rpfc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfc_in_if
// Input pixel channel: valid/ready with one RGB565 pixel.
// ----------------------------------------------------------------------------
interface rpfc_in_if
    import rpfc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] source_pixel;

    modport source (output valid, output source_pixel, input ready);
    modport sink   (input valid, input source_pixel, output ready);
endinterface

### sv/rpfc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpfc_out_if
// Output channel: valid/ready with wire-order bytes and their count.
// ----------------------------------------------------------------------------
interface rpfc_out_if
    import rpfc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] wire_bytes;
    logic [CNT_W-1:0]  byte_count;

    modport source (output valid, output wire_bytes, output byte_count, input ready);
    modport sink   (input valid, input wire_bytes, input byte_count, output ready);
endinterface

### sv/rgb565_pixel_format_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_pixel_format_converter
// RGB565 to client true-color pixel conversion, one pixel per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while the output is not stalled and returns
// one result per pixel through six register stages: the component multiply,
// the reciprocal-series quotient estimate, the remainder, the quotient
// correction, the shift/OR into the pixel word and the byte formatting. A
// stall at the output fills empty stages first, so gaps in the stream are
// squeezed out. Configuration must be written while no pixel is in flight.
// ----------------------------------------------------------------------------
module rgb565_pixel_format_converter
    import rpfc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    rpfc_in_if.sink              i_pix,
    rpfc_out_if.source           o_pix
);

    localparam int NST = 6;
    localparam logic [NLANE-1:0] LANE_SIX = 3'b010;  // green divides by 63

    // configuration
    logic [1:0]       r_size_mode;
    logic             r_swap;
    logic [MAX_W-1:0] r_max [NLANE];
    logic [POS_W-1:0] r_pos [NLANE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_mode <= SIZE_TWO;
            r_swap      <= 1'b0;
            r_max[0]    <= 16'd31;
            r_max[1]    <= 16'd63;
            r_max[2]    <= 16'd31;
            r_pos[0]    <= 5'd11;
            r_pos[1]    <= 5'd5;
            r_pos[2]    <= 5'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PIXEL_SIZE_MODE: r_size_mode <= i_cfg_data[1:0];
                CFG_SWAP_BYTES:      r_swap      <= i_cfg_data[0];
                CFG_RED_MAX:         r_max[0]    <= i_cfg_data;
                CFG_GREEN_MAX:       r_max[1]    <= i_cfg_data;
                CFG_BLUE_MAX:        r_max[2]    <= i_cfg_data;
                CFG_RED_POS:         r_pos[0]    <= i_cfg_data[POS_W-1:0];
                CFG_GREEN_POS:       r_pos[1]    <= i_cfg_data[POS_W-1:0];
                CFG_BLUE_POS:        r_pos[2]    <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // stage control: a stage loads when empty or when its successor moves
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_adv;

    always_comb begin
        w_adv[NST-1] = !r_vld[NST-1] || o_pix.ready;
        for (int s = NST-2; s >= 0; s--) begin
            w_adv[s] = !r_vld[s] || w_adv[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int s = 1; s < NST; s++) begin
                if (w_adv[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign i_pix.ready = w_adv[0];

    // component split
    logic [5:0] w_comp [NLANE];
    assign w_comp[0] = {1'b0, i_pix.source_pixel[15:11]};
    assign w_comp[1] = i_pix.source_pixel[10:5];
    assign w_comp[2] = {1'b0, i_pix.source_pixel[4:0]};

    t_x         r_x1  [NLANE];
    t_x         r_x2  [NLANE];
    t_q         r_q2  [NLANE];
    t_q         r_q3  [NLANE];
    t_rem       r_rem [NLANE];
    t_q         r_q4  [NLANE];
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_wire;
    logic [CNT_W-1:0]  r_cnt;

    logic [WORD_W-1:0] w_word;
    always_comb begin
        w_word = '0;
        for (int l = 0; l < NLANE; l++) begin
            w_word = w_word | ({{(WORD_W-QW){1'b0}}, r_q4[l]} << r_pos[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NLANE; l++) begin
            // stage 1: c * max + half of the source maximum
            if (w_adv[0]) begin
                r_x1[l] <= XW'({{(XW-6){1'b0}}, w_comp[l]}
                              * {{(XW-MAX_W){1'b0}}, r_max[l]})
                         + (LANE_SIX[l] ? XW'(31) : XW'(15));
            end
            // stage 2: quotient estimate
            if (w_adv[1]) begin
                r_x2[l] <= r_x1[l];
                r_q2[l] <= est_quot(r_x1[l], LANE_SIX[l]);
            end
            // stage 3: what the estimate left over
            if (w_adv[2]) begin
                r_q3[l]  <= r_q2[l];
                r_rem[l] <= remainder(r_x2[l], r_q2[l], LANE_SIX[l]);
            end
            // stage 4: corrected quotient
            if (w_adv[3]) begin
                r_q4[l] <= r_q3[l] + QW'(rem_quot(r_rem[l], LANE_SIX[l]));
            end
        end
        // stage 5: place components, bits past 31 drop out
        if (w_adv[4]) begin
            r_word <= w_word;
        end
        // stage 6: wire byte order
        if (w_adv[5]) begin
            case (r_size_mode)
                SIZE_FOUR: begin
                    r_cnt  <= CNT_FOUR;
                    r_wire <= r_swap ? {r_word[7:0], r_word[15:8],
                                        r_word[23:16], r_word[31:24]}
                                     : r_word;
                end
                SIZE_TWO: begin
                    r_cnt  <= CNT_TWO;
                    r_wire <= r_swap ? {16'h0000, r_word[7:0], r_word[15:8]}
                                     : {16'h0000, r_word[15:0]};
                end
                default: begin
                    r_cnt  <= CNT_ONE;
                    r_wire <= {24'h000000, r_word[7:0]};
                end
            endcase
        end
    end

    assign o_pix.valid      = r_vld[NST-1];
    assign o_pix.wire_bytes = r_wire;
    assign o_pix.byte_count = r_cnt;

`ifndef SYNTHESIS
    // the series estimate may leave at most five (red/blue) or four (green)
    // divisors behind, or the correction table runs out
    a_rem_rb_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> r_rem[0] < 9'd186 && r_rem[2] < 9'd186)
        else $error("red/blue remainder out of correction range");
    a_rem_green_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> r_rem[1] < 9'd315)
        else $error("green remainder out of correction range");
    // an accepted pixel always lands in the first stage
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_vld[0])
        else $error("accepted pixel lost at stage 1");
    // bytes above the pixel size are zero
    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> (o_pix.byte_count == CNT_FOUR)
                     || (o_pix.byte_count == CNT_TWO && o_pix.wire_bytes[31:16] == 16'h0)
                     || (o_pix.byte_count == CNT_ONE && o_pix.wire_bytes[31:8] == 24'h0))
        else $error("bad byte count or stray upper bytes");
    // a stalled result stays in the last stage
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NST-1] && !o_pix.ready |=> r_vld[NST-1] && $stable(r_wire))
        else $error("stalled result dropped or changed");
`endif

endmodule
